// ===== hw/rtl/gwm_pkg.sv =====
// Shared types and constants of the glob wildcard matcher.
// No dependencies; imported by every RTL module of the matcher but gwm_checker.
package gwm_pkg;

  // Pattern characters with a special meaning.
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_ANY  = 8'h3F;
  localparam logic [7:0] CH_DOT  = 8'h2E;

  // Register index of the hidden-name control bit (byte address bit 2).
  localparam logic CFG_IDX_HIDE_DOT = 1'b0;

  // Operation carried by one input transfer.
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_NAME   = 2'd2,
    OP_END    = 2'd3
  } op_e;

  // Write request into the pattern store.
  typedef struct packed {
    logic       en;
    logic [7:0] value;
  } pat_wr_t;

endpackage

// ===== hw/rtl/gwm_pattern_store.sv =====
// Pattern store of the glob matcher: one byte cell per pattern position.
// Depends on gwm_pkg. Each cell also keeps its star and any-byte flags.
module gwm_pattern_store
  import gwm_pkg::*;
#(
  parameter int MAX_PATTERN = 64,
  localparam int LenW = $clog2(MAX_PATTERN + 1)
) (
  input  logic                  clk_i,
  input  pat_wr_t               wr_i,
  input  logic [LenW-1:0]       wr_pos_i,
  output logic [MAX_PATTERN-1:0] star_o,
  output logic [MAX_PATTERN-1:0] any_o,
  output logic [7:0]            byte_o [MAX_PATTERN]
);

  logic [7:0]             byte_q [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] star_q;
  logic [MAX_PATTERN-1:0] any_q;

  // Entries are written once each, at the position equal to the current
  // pattern length; positions at or above the length are never consulted.
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (wr_i.en && (wr_pos_i == LenW'(j))) begin
        byte_q[j] <= wr_i.value;
        star_q[j] <= (wr_i.value == CH_STAR);
        any_q[j]  <= (wr_i.value == CH_ANY);
      end
    end
  end

  assign byte_o = byte_q;
  assign star_o = star_q;
  assign any_o  = any_q;

endmodule

// ===== hw/rtl/gwm_row_update.sv =====
// Next match row for one name byte, as a segmented prefix OR over the row.
// Depends on gwm_pkg; fed by gwm_pattern_store and the row register.
module gwm_row_update
  import gwm_pkg::*;
#(
  parameter int MAX_PATTERN = 64,
  localparam int LenW = $clog2(MAX_PATTERN + 1),
  localparam int NLev = $clog2(MAX_PATTERN + 1)
) (
  input  logic [MAX_PATTERN:0]   row_i,
  input  logic [LenW-1:0]        len_i,
  input  logic [MAX_PATTERN-1:0] star_i,
  input  logic [MAX_PATTERN-1:0] any_i,
  input  logic [7:0]             byte_i [MAX_PATTERN],
  input  logic [7:0]             name_byte_i,
  output logic [MAX_PATTERN:0]   next_o
);

  // Each position either starts a segment (non-star, inactive or position
  // zero) with its own value, or is a star that ORs in everything back to
  // the segment start.
  logic [MAX_PATTERN:0] seg_v [NLev+1];
  logic [MAX_PATTERN:0] seg_f [NLev+1];

  always_comb begin
    seg_v[0][0] = 1'b0;
    seg_f[0][0] = 1'b1;
    for (int j = 1; j <= MAX_PATTERN; j++) begin
      if (LenW'(j) > len_i) begin
        seg_v[0][j] = 1'b0;
        seg_f[0][j] = 1'b1;
      end else if (star_i[j-1]) begin
        seg_v[0][j] = row_i[j];
        seg_f[0][j] = 1'b0;
      end else begin
        seg_v[0][j] = row_i[j-1] & (any_i[j-1] | (byte_i[j-1] == name_byte_i));
        seg_f[0][j] = 1'b1;
      end
    end
    for (int l = 0; l < NLev; l++) begin
      for (int j = 0; j <= MAX_PATTERN; j++) begin
        if ((j >= (1 << l)) && !seg_f[l][j]) begin
          seg_v[l+1][j] = seg_v[l][j] | seg_v[l][j-(1 << l)];
          seg_f[l+1][j] = seg_f[l][j-(1 << l)];
        end else begin
          seg_v[l+1][j] = seg_v[l][j];
          seg_f[l+1][j] = seg_f[l][j];
        end
      end
    end
  end

  assign next_o = seg_v[NLev];

endmodule

// ===== hw/rtl/glob_wildcard_matcher_top.sv =====
// Top level of the streaming glob wildcard matcher ('*' and '?').
// Depends on gwm_pkg, gwm_pattern_store and gwm_row_update.
//
//   Channel | Direction | Signals                                   | Transfer when
//   --------+-----------+-------------------------------------------+----------------------
//   in      | input     | opcode_i, byte_value_i                    | in_valid_i & in_ready_o
//   out     | output    | matched_o, hidden_rejected_o,             | out_valid_o & out_ready_i
//           |           | pattern_overflow_o                        |
//   cfg     | APB       | psel, penable, pwrite, paddr, pwdata      | psel & penable & pwrite
//
// Every input transfer passes through the input register and then the state update,
// so one item is accepted per cycle unless an end-of-name item waits on a full,
// stalled result register; an end-of-name result goes from the input register into
// the result register. The match row update is a segmented prefix OR of
// $clog2(MAX_PATTERN + 1) levels, which sets the clock path.
// Reset clears the pattern length, the flags and the row; the pattern bytes
// themselves hold no reset value. A stalled output stops only an end-of-name item
// in the input register; clear, append and name-byte items keep flowing.
module glob_wildcard_matcher_top
  import gwm_pkg::*;
#(
  parameter int MAX_PATTERN = 64,
  localparam int LenW = $clog2(MAX_PATTERN + 1)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Item input channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  byte_value_i,
  // Result output channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        matched_o,
  output logic        hidden_rejected_o,
  output logic        pattern_overflow_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------------------
  // Configuration register. The only register sits at byte address 0; the
  // word index is address bit 2 and the byte-lane bits are ignored.
  // ---------------------------------------------------------------------------
  logic hide_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hide_q <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        CFG_IDX_HIDE_DOT: hide_q <= pwdata[0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_IDX_HIDE_DOT: prdata = {31'b0, hide_q};
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register. It advances unless it holds an end-of-name item whose
  // result cannot be written because the output register is still full.
  // ---------------------------------------------------------------------------
  logic       s1_valid_q;
  op_e        s1_op_q;
  logic [7:0] s1_byte_q;
  logic       s1_adv;
  logic       out_valid_q;

  assign s1_adv     = s1_valid_q && ((s1_op_q != OP_END) || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_op_q   <= op_e'(opcode_i);
      s1_byte_q <= byte_value_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Matcher state.
  // ---------------------------------------------------------------------------
  logic [LenW-1:0]        len_q, len_d;
  logic [LenW-1:0]        lead_cnt_q, lead_cnt_d;
  logic                   lead_q, lead_d;
  logic                   start_q, start_d;
  logic                   dot_q, dot_d;
  logic                   ovf_q, ovf_d;
  logic [MAX_PATTERN:0]   row_q, row_d;

  logic [MAX_PATTERN-1:0] pat_star;
  logic [MAX_PATTERN-1:0] pat_any;
  logic [7:0]             pat_byte [MAX_PATTERN];
  logic [MAX_PATTERN:0]   row_next;
  pat_wr_t                pat_wr;
  logic                   pat_full;
  logic                   restart;

  assign pat_full     = (len_q == LenW'(MAX_PATTERN));
  assign pat_wr.en    = s1_adv && (s1_op_q == OP_APPEND) && !pat_full;
  assign pat_wr.value = s1_byte_q;

  gwm_pattern_store #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_store (
    .clk_i    (clk_i),
    .wr_i     (pat_wr),
    .wr_pos_i (len_q),
    .star_o   (pat_star),
    .any_o    (pat_any),
    .byte_o   (pat_byte)
  );

  gwm_row_update #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_row (
    .row_i       (row_q),
    .len_i       (len_q),
    .star_i      (pat_star),
    .any_i       (pat_any),
    .byte_i      (pat_byte),
    .name_byte_i (s1_byte_q),
    .next_o      (row_next)
  );

  // End-of-name evaluation straight from the current state.
  logic hit;
  logic dot_pattern;
  logic reject;

  assign hit         = row_q[len_q];
  assign dot_pattern = (len_q != '0) && (pat_byte[0] == CH_DOT);
  assign reject      = hide_q && dot_q && !dot_pattern;

  always_comb begin
    len_d      = len_q;
    lead_cnt_d = lead_cnt_q;
    lead_d     = lead_q;
    start_d    = start_q;
    dot_d      = dot_q;
    ovf_d      = ovf_q;
    row_d      = row_q;
    restart    = 1'b0;
    if (s1_adv) begin
      case (s1_op_q)
        OP_CLEAR: begin
          len_d      = '0;
          lead_cnt_d = '0;
          lead_d     = 1'b1;
          ovf_d      = 1'b0;
          restart    = 1'b1;
        end
        OP_APPEND: begin
          if (pat_full) begin
            ovf_d = 1'b1;
          end else begin
            len_d = len_q + LenW'(1);
            if (lead_q && (s1_byte_q == CH_STAR)) begin
              lead_cnt_d = lead_cnt_q + LenW'(1);
            end else begin
              lead_d = 1'b0;
            end
          end
          restart = 1'b1;
        end
        OP_NAME: begin
          if (start_q) begin
            dot_d   = (s1_byte_q == CH_DOT);
            start_d = 1'b0;
          end
          row_d = row_next;
        end
        default: begin
          restart = 1'b1;
        end
      endcase
    end
    // The empty-name row is true for prefix zero and every leading star.
    if (restart) begin
      for (int j = 0; j <= MAX_PATTERN; j++) begin
        row_d[j] = (LenW'(j) <= lead_cnt_d);
      end
      start_d = 1'b1;
      dot_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      lead_cnt_q <= '0;
      lead_q     <= 1'b1;
      start_q    <= 1'b1;
      dot_q      <= 1'b0;
      ovf_q      <= 1'b0;
      row_q      <= (MAX_PATTERN + 1)'(1);
    end else begin
      len_q      <= len_d;
      lead_cnt_q <= lead_cnt_d;
      lead_q     <= lead_d;
      start_q    <= start_d;
      dot_q      <= dot_d;
      ovf_q      <= ovf_d;
      row_q      <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. It is loaded by an end-of-name item and emptied by an
  // output transfer; the guard on s1_adv keeps a full register from being
  // overwritten.
  // ---------------------------------------------------------------------------
  logic matched_q;
  logic hidden_q;
  logic ovf_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && (s1_op_q == OP_END)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && (s1_op_q == OP_END)) begin
      matched_q <= hit && !reject;
      hidden_q  <= hit && reject;
      ovf_out_q <= ovf_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign matched_o          = matched_q;
  assign hidden_rejected_o  = hidden_q;
  assign pattern_overflow_o = ovf_out_q;

endmodule

// ===== hw/rtl/gwm_checker.sv =====
// Port-level checks of the glob wildcard matcher, bound to its top level.
// Depends on glob_wildcard_matcher_top only through the bind below.
module gwm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic matched_o,
  input logic hidden_rejected_o,
  input logic pattern_overflow_o
);

  // A result waiting for its transfer stays, with the same fields.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(matched_o) &&
      $stable(hidden_rejected_o) && $stable(pattern_overflow_o))
    else $error("result changed or vanished while stalled");

  // The dot rule only rejects a name that matched, so both flags never show.
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(matched_o && hidden_rejected_o))
    else $error("matched and hidden_rejected both set");

  // Input back-pressure comes only from a full result register that is stalled.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without an output stall");

endmodule

bind glob_wildcard_matcher_top gwm_checker u_gwm_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .matched_o          (matched_o),
  .hidden_rejected_o  (hidden_rejected_o),
  .pattern_overflow_o (pattern_overflow_o)
);
